### rtl/hashed_key_value_table_unit_defines.svh
// Assertion macros shared by the hash table checker.
// No dependencies; included by the checker file only.
`ifndef HASHED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define HASHED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HKV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hash table checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define HKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hash table checker: next-cycle property failed");

`endif

### rtl/hkv_pkg.sv
// Shared constants, control types and hash helpers for the hash table unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package hkv_pkg;

  // Request codes.
  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Width of the reported entry count.
  localparam int unsigned ENTRY_W = 11;

  // Integer hash constants.
  localparam logic [31:0] WANG_SEED = 32'd61;
  localparam logic [31:0] WANG_MUL  = 32'h27d4eb2d;
  localparam int unsigned WANG_SH1  = 16;
  localparam int unsigned WANG_SH2  = 3;
  localparam int unsigned WANG_SH3  = 4;
  localparam int unsigned WANG_SH4  = 15;

  // Strobes from the sequencer to the bucket store.
  typedef struct packed {
    logic rd_en;
    logic row_we;
    logic fill_we;
  } mem_ctrl_t;

  // Hash steps ahead of the multiply: xor/shift, times nine, xor/shift.
  function automatic logic [31:0] wang_pre(input logic [31:0] a);
    logic [31:0] b;
    b = (a ^ WANG_SEED) ^ (a >> WANG_SH1);
    b = b + (b << WANG_SH2);
    b = b ^ (b >> WANG_SH3);
    return b;
  endfunction

  // Hash step after the multiply.
  function automatic logic [31:0] wang_post(input logic [31:0] a);
    return a ^ (a >> WANG_SH4);
  endfunction

endpackage

`default_nettype wire

### rtl/hkv_hash.sv
// Multi-cycle bucket index unit: integer hash of the key, then reduction to
// a bucket number. Depends on hkv_pkg.
`default_nettype none

module hkv_hash import hkv_pkg::*; #(
  parameter int unsigned BUCKETS = 256,
  localparam int unsigned BW = $clog2(BUCKETS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   key_i,
  output logic               done_o,
  output logic [BW-1:0]      bucket_o
);

  logic [31:0] mix_q;
  logic [31:0] prod_q;
  logic        mix_vld_q;
  logic        prod_vld_q;
  logic [31:0] hash_w;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      mix_vld_q  <= start_i;
      prod_vld_q <= mix_vld_q;
    end
  end

  // Pre-mix stage, then the 32-bit multiply with its own register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mix_q <= wang_pre(key_i);
    end
    if (mix_vld_q) begin
      prod_q <= mix_q * WANG_MUL;
    end
  end

  assign hash_w = wang_post(prod_q);

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
    logic          done_q;
    logic [BW-1:0] bucket_q;

    // A power-of-two bucket count keeps the low hash bits.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= prod_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (prod_vld_q) begin
        bucket_q <= hash_w[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bucket_q;
  end else begin : g_mod
    // Reciprocal of the bucket count scaled by 2^32, and the count itself.
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));
    localparam logic [31:0] BKT   = 32'(BUCKETS);

    logic [31:0]   quo_w;
    logic [31:0]   hsh_q;
    logic [31:0]   quo_q;
    logic [31:0]   rem_q;
    logic          quo_vld_q;
    logic          rem_vld_q;
    logic          done_q;
    logic [BW-1:0] bucket_q;

    // Quotient estimate from the reciprocal; it is low by at most one, so
    // the first remainder is below twice the bucket count.
    assign quo_w = 32'(({32'd0, hash_w} * {32'd0, RECIP}) >> 32);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        quo_vld_q <= 1'b0;
        rem_vld_q <= 1'b0;
        done_q    <= 1'b0;
      end else begin
        quo_vld_q <= prod_vld_q;
        rem_vld_q <= quo_vld_q;
        done_q    <= rem_vld_q;
      end
    end

    // Estimate, back-multiply and subtract, then one correcting subtract.
    always_ff @(posedge clk_i) begin
      if (prod_vld_q) begin
        hsh_q <= hash_w;
        quo_q <= quo_w;
      end
      if (quo_vld_q) begin
        rem_q <= hsh_q - (quo_q * BKT);
      end
      if (rem_vld_q) begin
        bucket_q <= (rem_q >= BKT) ? BW'(rem_q - BKT) : BW'(rem_q);
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bucket_q;
  end

endmodule

`default_nettype wire

### rtl/hkv_store.sv
// Bucket store: one row of keys and values per bucket plus a fill memory,
// each with a registered read port. Depends on hkv_pkg.
`default_nettype none

module hkv_store import hkv_pkg::*; #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 4,
  localparam int unsigned BW = $clog2(BUCKETS),
  localparam int unsigned FW = $clog2(WAYS + 1)
) (
  input  wire logic                  clk_i,
  input  wire mem_ctrl_t             mem_ctrl_i,
  input  wire logic [BW-1:0]         addr_i,
  input  wire logic [WAYS-1:0][31:0] wr_keys_i,
  input  wire logic [WAYS-1:0][31:0] wr_vals_i,
  input  wire logic [FW-1:0]         wr_fill_i,
  output logic [WAYS-1:0][31:0]      rd_keys_o,
  output logic [WAYS-1:0][31:0]      rd_vals_o,
  output logic [FW-1:0]              rd_fill_o
);

  logic [WAYS-1:0][31:0] key_mem  [BUCKETS];
  logic [WAYS-1:0][31:0] val_mem  [BUCKETS];
  logic [FW-1:0]         fill_mem [BUCKETS];

  // Row memory: whole-row write, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_ctrl_i.row_we) begin
      key_mem[addr_i] <= wr_keys_i;
      val_mem[addr_i] <= wr_vals_i;
    end
    if (mem_ctrl_i.rd_en) begin
      rd_keys_o <= key_mem[addr_i];
      rd_vals_o <= val_mem[addr_i];
    end
  end

  // Fill memory, cleared by the sequencer after reset.
  always_ff @(posedge clk_i) begin
    if (mem_ctrl_i.fill_we) begin
      fill_mem[addr_i] <= wr_fill_i;
    end
    if (mem_ctrl_i.rd_en) begin
      rd_fill_o <= fill_mem[addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/hashed_key_value_table_unit.sv
// Top level of the hashed key/value table: request sequencer, bucket update
// logic and result register. Depends on hkv_pkg, hkv_hash and hkv_store.
//
// Usage:
// - Input channel (in_valid_i/in_stall_o) carries one put, get or remove
//   request per transfer; output channel (out_valid_o/out_stall_i) returns
//   exactly one result per request, in request order.
// - Requests are handled one at a time: a new request is taken only after the
//   result of the last one is loaded into the result register. Any other
//   bucket count than a power of two adds the quotient and remainder
//   registers of the reciprocal remainder in the hash unit to each request.
// - Each request does one read of its bucket row and, if it changes the bucket,
//   one write-back; the ways are compared in parallel in the update cycle.
// - After reset the fill memory is cleared one bucket per cycle, while
//   in_stall_o stays high.
// - A waiting result does not block the next request: the block accepts it
//   and runs it up to the update, which holds until the result register
//   is free. A stalled result keeps its value until transferred.
`default_nettype none

module hashed_key_value_table_unit import hkv_pkg::*; #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] lookup_key_i,
  input  wire logic signed [31:0] put_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      found_value_o,
  output logic [1:0]              status_o,
  output logic [ENTRY_W-1:0]      entry_count_o
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned FW = $clog2(WAYS + 1);
  localparam int unsigned TW = $clog2(BUCKETS * WAYS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_HASH   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [BW-1:0]         clr_q, clr_d;
  logic [1:0]            op_q;
  logic [31:0]           key_q;
  logic [31:0]           val_q;
  logic [BW-1:0]         bucket_q;
  logic [TW-1:0]         total_q, total_d;
  logic                  out_valid_q;
  logic [31:0]           found_q;
  logic [1:0]            status_q;
  logic [ENTRY_W-1:0]    count_q;

  logic                  accept;
  logic                  out_free;
  logic                  commit;
  logic                  hash_done;
  logic [BW-1:0]         hash_bucket;
  mem_ctrl_t             mem_ctrl;
  logic [BW-1:0]         mem_addr;
  logic [WAYS-1:0][31:0] rd_keys;
  logic [WAYS-1:0][31:0] rd_vals;
  logic [FW-1:0]         rd_fill;
  logic [WAYS-1:0][31:0] new_keys;
  logic [WAYS-1:0][31:0] new_vals;
  logic [FW-1:0]         new_fill;
  logic [FW-1:0]         fill_c;
  logic [FW-1:0]         pos;
  logic                  hit;
  logic                  change;
  logic [31:0]           found_d;
  logic [1:0]            status_d;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_UPDATE) && out_free;

  hkv_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .key_i    (lookup_key_i),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  // Store strobes and address: clearing pass, bucket read, write-back.
  always_comb begin
    mem_ctrl.rd_en   = (state_q == ST_HASH) && hash_done;
    mem_ctrl.row_we  = commit && change;
    mem_ctrl.fill_we = (state_q == ST_CLEAR) || (commit && change);
    if (state_q == ST_CLEAR) begin
      mem_addr = clr_q;
    end else if (state_q == ST_HASH) begin
      mem_addr = hash_bucket;
    end else begin
      mem_addr = bucket_q;
    end
  end

  hkv_store #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_store (
    .clk_i      (clk_i),
    .mem_ctrl_i (mem_ctrl),
    .addr_i     (mem_addr),
    .wr_keys_i  (new_keys),
    .wr_vals_i  (new_vals),
    .wr_fill_i  ((state_q == ST_CLEAR) ? '0 : new_fill),
    .rd_keys_o  (rd_keys),
    .rd_vals_o  (rd_vals),
    .rd_fill_o  (rd_fill)
  );

  // Newest matching way among the filled ones.
  always_comb begin
    fill_c = (rd_fill > FW'(WAYS)) ? FW'(WAYS) : rd_fill;
    hit    = 1'b0;
    pos    = '0;
    for (int i = 0; i < WAYS; i++) begin
      if ((FW'(i) < fill_c) && (rd_keys[i] == key_q)) begin
        hit = 1'b1;
        pos = FW'(i);
      end
    end
  end

  // Bucket update and result for the current request.
  always_comb begin
    new_keys = rd_keys;
    new_vals = rd_vals;
    new_fill = fill_c;
    total_d  = total_q;
    change   = 1'b0;
    found_d  = '0;
    status_d = ST_OK;
    case (op_q)
      OP_PUT: begin
        if (fill_c >= FW'(WAYS)) begin
          status_d = ST_FULL;
        end else begin
          for (int i = 0; i < WAYS; i++) begin
            if (FW'(i) == fill_c) begin
              new_keys[i] = key_q;
              new_vals[i] = val_q;
            end
          end
          new_fill = fill_c + FW'(1);
          total_d  = total_q + TW'(1);
          change   = 1'b1;
        end
      end
      OP_GET: begin
        if (!hit) begin
          status_d = ST_MISSING;
        end else begin
          for (int i = 0; i < WAYS; i++) begin
            if (FW'(i) == pos) begin
              found_d = rd_vals[i];
            end
          end
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          status_d = ST_MISSING;
        end else begin
          // Close the gap: entries above the match move down one way.
          for (int i = 0; i < WAYS - 1; i++) begin
            if ((FW'(i) >= pos) && (FW'(i + 1) < fill_c)) begin
              new_keys[i] = rd_keys[i + 1];
              new_vals[i] = rd_vals[i + 1];
            end
          end
          new_fill = fill_c - FW'(1);
          total_d  = (total_q != '0) ? (total_q - TW'(1)) : total_q;
          change   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (commit) begin
        total_q <= total_d;
      end
    end
  end

  // Request capture and bucket latch.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= lookup_key_i;
      val_q <= put_value_i;
    end
    if ((state_q == ST_HASH) && hash_done) begin
      bucket_q <= hash_bucket;
    end
  end

  // Result register: loads on commit, empties on an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      found_q  <= found_d;
      status_q <= status_d;
      count_q  <= ENTRY_W'(total_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_value_o = found_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

`default_nettype wire

### rtl/hkv_checker.sv
// Port-level checker for the hashed key/value table unit, bound to the top.
// Depends on hkv_pkg and hashed_key_value_table_unit_defines.svh.
`default_nettype none
`include "hashed_key_value_table_unit_defines.svh"

module hkv_checker import hkv_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] found_value_o,
  input wire logic [1:0]         status_o,
  input wire logic [ENTRY_W-1:0] entry_count_o
);

  // Requests are handled one at a time, so a transfer closes the input.
  `HKV_ASSERT_NEXT(a_single_request, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Results only carry defined status codes.
  `HKV_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, (status_o == ST_OK || status_o == ST_MISSING || status_o == ST_FULL))

  // A failed request reports a zero value.
  `HKV_ASSERT_NOW(a_zero_on_fail, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), found_value_o == '0)

  // A stalled result holds.
  `HKV_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(found_value_o) && $stable(status_o) && $stable(entry_count_o))

endmodule

bind hashed_key_value_table_unit hkv_checker u_hkv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .found_value_o (found_value_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the hashed key/value table unit.
// Depends on hkv_pkg and hashed_key_value_table_unit; a local table model
// predicts every result, and random bursts and stalls exercise both channels.
`default_nettype none

module tb_top;
  import hkv_pkg::*;

  localparam int unsigned BUCKETS        = 256;
  localparam int unsigned WAYS           = 4;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned HOT_BUCKETS    = 6;
  localparam int unsigned HOT_DEPTH      = 8;
  localparam int unsigned RECENT_DEPTH   = 64;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned END_CYCLES     = 10;
  localparam int unsigned PRINT_LIMIT    = 40;

  // Integer hash constants.
  localparam logic [31:0] HASH_SEED = 32'd61;
  localparam logic [31:0] HASH_MUL  = 32'h27d4eb2d;

  typedef struct packed {
    logic signed [31:0]   value;
    logic [1:0]           status;
    logic [ENTRY_W-1:0]   count;
  } table_result_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              opcode_i      = OP_PUT;
  logic signed [31:0]      lookup_key_i  = '0;
  logic signed [31:0]      put_value_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic signed [31:0]      found_value_o;
  logic [1:0]              status_o;
  logic [ENTRY_W-1:0]      entry_count_o;

  // Shadow copy of the table contents.
  logic [31:0]             tbl_key [BUCKETS][WAYS];
  logic [31:0]             tbl_val [BUCKETS][WAYS];
  int                      tbl_fill [BUCKETS];
  int unsigned             tbl_total = 0;

  table_result_t           expected_results [$];
  logic [31:0]             recent_keys [$];
  logic [31:0]             hot_keys [HOT_BUCKETS*HOT_DEPTH];
  int unsigned             mismatches = 0;
  int unsigned             idle_cycles = 0;
  bit                      hold_results_req = 1'b0;

  hashed_key_value_table_unit #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .lookup_key_i (lookup_key_i),
    .put_value_i  (put_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_value_o(found_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Integer hash of a key; the bucket is the hash modulo the bucket count.
  function automatic logic [31:0] wang_hash(input logic [31:0] a);
    logic [31:0] h;
    h = (a ^ HASH_SEED) ^ (a >> 16);
    h = h + (h << 3);
    h = h ^ (h >> 4);
    h = h * HASH_MUL;
    h = h ^ (h >> 15);
    return h;
  endfunction

  // Applies one request to the shadow table and returns the result it gives.
  function automatic table_result_t apply_request(input logic [1:0] op,
                                                  input logic [31:0] key,
                                                  input logic [31:0] val);
    table_result_t r;
    int unsigned   b;
    int            fill;
    int            hit;
    b        = wang_hash(key) % BUCKETS;
    fill     = tbl_fill[b];
    hit      = -1;
    r.value  = '0;
    r.status = ST_OK;
    // Newest matching entry sits at the highest index.
    for (int i = fill - 1; i >= 0; i--) begin
      if (hit < 0 && tbl_key[b][i] == key) hit = i;
    end
    case (op)
      OP_PUT: begin
        if (fill >= WAYS) begin
          r.status = ST_FULL;
        end else begin
          tbl_key[b][fill] = key;
          tbl_val[b][fill] = val;
          tbl_fill[b]      = fill + 1;
          tbl_total++;
        end
      end
      OP_GET: begin
        if (hit < 0) r.status = ST_MISSING;
        else r.value = tbl_val[b][hit];
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          // Close the gap so the bucket stays ordered oldest first.
          for (int i = hit; i + 1 < fill; i++) begin
            tbl_key[b][i] = tbl_key[b][i+1];
            tbl_val[b][i] = tbl_val[b][i+1];
          end
          tbl_fill[b] = fill - 1;
          if (tbl_total > 0) tbl_total--;
        end
      end
      default: begin
      end
    endcase
    r.count = tbl_total[ENTRY_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT) begin
      $display("ERROR at %0t: %s, got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Offers one request and records its expected result on transfer.
  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input logic [31:0] val);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    lookup_key_i <= key;
    put_value_i  <= val;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_request(op, key, val));
    if (op == OP_PUT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops offering requests until every pending result has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Random requests in bursts; most keys land in a few crowded buckets or
  // repeat recent puts so that gets, removes and full buckets hit often.
  task automatic run_random_items(input int unsigned count,
                                  input int unsigned max_gap);
    int unsigned burst_left;
    int unsigned pick;
    int unsigned gap;
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] val;
    burst_left = $urandom_range(1, 40);
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_PUT;
      else if (pick < 70) op = OP_GET;
      else if (pick < 95) op = OP_REMOVE;
      else op = OP_UNUSED;

      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        key = hot_keys[$urandom_range(0, HOT_BUCKETS*HOT_DEPTH-1)];
      end else if (pick < 70 && recent_keys.size() != 0) begin
        key = recent_keys[$urandom_range(0, recent_keys.size()-1)];
      end else if (pick < 80) begin
        case ($urandom_range(0, 4))
          0: key = 32'h0000_0000;
          1: key = 32'hffff_ffff;
          2: key = 32'h8000_0000;
          3: key = 32'h7fff_ffff;
          default: key = $urandom_range(0, 15);
        endcase
      end else begin
        key = $urandom;
      end

      if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      else val = $urandom;

      send_request(op, key, val);
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, max_gap);
        if (gap != 0) pause_sender(gap);
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  // Gets and removes on an empty table miss.
  task automatic test_empty_table();
    send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_REMOVE, 32'h7fff_ffff, 32'h0);
  endtask

  // Extreme keys and values round trip through the table.
  task automatic test_extreme_keys();
    send_request(OP_PUT, 32'h0000_0000, 32'h7fff_ffff);
    send_request(OP_PUT, 32'hffff_ffff, 32'h8000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_GET, 32'hffff_ffff, 32'h0);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_GET, 32'h7fff_ffff, 32'h0);
  endtask

  // A duplicate key shadows the older entry until it is removed.
  task automatic test_duplicates();
    send_request(OP_PUT, 32'h0000_0000, 32'h5a5a_5a5a);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_REMOVE, 32'h0000_0000, 32'hffff_ffff);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
  endtask

  // One bucket overflows, then a middle entry is removed.
  task automatic test_full_bucket();
    for (int i = 0; i <= WAYS; i++) begin
      send_request(OP_PUT, hot_keys[i], $urandom);
    end
    send_request(OP_REMOVE, hot_keys[1], 32'h0);
    send_request(OP_GET, hot_keys[2], 32'h0);
    send_request(OP_GET, hot_keys[1], 32'h0);
  endtask

  task automatic test_unused_opcode();
    send_request(OP_UNUSED, hot_keys[0], 32'hffff_ffff);
  endtask

  task automatic test_random_traffic();
    run_random_items(900, 12);
  endtask

  // Results are held off for a long stretch while requests keep coming.
  task automatic test_result_backpressure();
    hold_results_req = 1'b1;
    run_random_items(20, 0);
    drain_results();
  endtask

  // Random traffic with a full drain in the middle.
  task automatic test_drain_and_resume();
    run_random_items(450, 12);
    drain_results();
    run_random_items(450, 12);
  endtask

  // Receiver stall patterns, with an occasional long hold-off on request.
  initial begin : result_stall_gen
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = STALL_NONE;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (hold_results_req) begin
        hold_results_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        tick++;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest pending expectation.
  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", found_value_o, 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (found_value_o !== want.value)
          report_mismatch("found_value", found_value_o, want.value);
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", 32'(entry_count_o), 32'(want.count));
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : test_sequence
    int unsigned target;
    int unsigned n;
    logic [31:0] cand;

    // Keys that share a handful of buckets, found by search.
    for (int h = 0; h < HOT_BUCKETS; h++) begin
      target = $urandom_range(0, BUCKETS - 1);
      n      = 0;
      while (n < HOT_DEPTH) begin
        cand = $urandom;
        if (wang_hash(cand) % BUCKETS == target) begin
          hot_keys[h*HOT_DEPTH + n] = cand;
          n++;
        end
      end
    end
    for (int b = 0; b < BUCKETS; b++) tbl_fill[b] = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_extreme_keys();
    test_duplicates();
    test_full_bucket();
    test_unused_opcode();
    test_random_traffic();
    test_result_backpressure();
    test_drain_and_resume();

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
